// ----- rtl/pcca_pkg.sv -----
// ----------------------------------------------------------------------------
// pcca_pkg
// Shared types, widths and codes of the per-cluster clip averager.
// ----------------------------------------------------------------------------
package pcca_pkg;

  // default store geometry
  localparam int DEF_MAX_CLUSTERS = 64;
  localparam int DEF_MAX_CHANNELS = 16;
  localparam int DEF_MAX_CLIP     = 64;
  localparam int DEF_QUEUE_DEPTH  = 4;

  // field widths
  localparam int CLUSTER_W = 6;
  localparam int CHANNEL_W = 4;
  localparam int TIME_W    = 6;
  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 40;
  localparam int COUNT_W   = 24;
  localparam int MEAN_W    = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int NCH_W      = 5;
  localparam int CLIP_W     = 7;
  localparam int NCL_W      = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 2'd2;

  // opcodes
  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_READ       = 1'b1;

  // saturation limits
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_POS_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]   SUM_NEG_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [MEAN_W-1:0]  MEAN_POS_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0]  MEAN_NEG_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

  typedef struct packed {
    logic                        opcode;
    logic [CLUSTER_W-1:0]        cluster_index;
    logic [CHANNEL_W-1:0]        channel_index;
    logic [TIME_W-1:0]           time_offset;
    logic signed [SAMPLE_W-1:0]  sample_value;
    logic                        end_of_event;
  } pcca_in_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean_value;
    logic [COUNT_W-1:0]       event_count;
    logic                     index_error;
  } pcca_out_t;

  // classified item handed from front to back
  typedef struct packed {
    pcca_in_t req;
    logic     in_range;
  } pcca_item_t;

endpackage

// ----- rtl/pcca_ram.sv -----
// ----------------------------------------------------------------------------
// pcca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pcca_div.sv -----
// ----------------------------------------------------------------------------
// pcca_div
// Bit-serial restoring divider: unsigned sum magnitude by event count,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcca_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pcca_pkg::SUM_W-1:0]   dividend,
  input  logic [pcca_pkg::COUNT_W-1:0] divisor,
  output logic                         done,
  output logic [pcca_pkg::SUM_W-1:0]   quotient
);

  localparam int DW = pcca_pkg::SUM_W;
  localparam int VW = pcca_pkg::COUNT_W;
  localparam int SW = $clog2(DW);

  logic          running;
  logic [SW-1:0] step;
  logic [VW-1:0] rem;
  logic [VW-1:0] dsr;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          ge;

  // trial subtract of one step
  always_comb begin
    rem_sh  = {rem, quotient[DW-1]};
    rem_sub = rem_sh - {1'b0, dsr};
    ge      = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        step     <= '0;
        quotient <= dividend;
        rem      <= '0;
        dsr      <= divisor;
      end else if (running) begin
        rem      <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
        quotient <= {quotient[DW-2:0], ge};
        step     <= step + 1'b1;
        if (step == SW'(DW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/pcca_queue.sv -----
// ----------------------------------------------------------------------------
// pcca_queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module pcca_queue #(
  parameter int DEPTH = pcca_pkg::DEF_QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pcca_pkg::pcca_item_t push_item,
  input  logic                 pop,
  output pcca_pkg::pcca_item_t head,
  output logic                 empty,
  output logic [CW-1:0]        count
);

  pcca_pkg::pcca_item_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/pcca_front.sv -----
// ----------------------------------------------------------------------------
// pcca_front
// Configuration registers, item acceptance and range classification.
// ----------------------------------------------------------------------------
module pcca_front #(
  parameter int MAX_CLUSTERS = pcca_pkg::DEF_MAX_CLUSTERS,
  parameter int MAX_CHANNELS = pcca_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_CLIP     = pcca_pkg::DEF_MAX_CLIP,
  parameter int QUEUE_DEPTH  = pcca_pkg::DEF_QUEUE_DEPTH,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  pcca_pkg::pcca_in_t              request,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcca_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            clearing,
  input  logic [CW-1:0]                   q_count,
  output logic                            push,
  output pcca_pkg::pcca_item_t            push_item
);

  localparam logic [31:0] MAX_CL_U = 32'(MAX_CLUSTERS);
  localparam logic [31:0] MAX_CH_U = 32'(MAX_CHANNELS);
  localparam logic [31:0] MAX_T_U  = 32'(MAX_CLIP);

  logic [pcca_pkg::NCH_W-1:0]  num_channels;
  logic [pcca_pkg::CLIP_W-1:0] clip_length;
  logic [pcca_pkg::NCL_W-1:0]  num_clusters;
  logic                        stage_valid;
  pcca_pkg::pcca_item_t        stage_item;
  logic                        accept;
  logic                        in_range;

  assign cfg_ready = 1'b1;

  // stall while the store clears or the queue could overflow
  assign busy   = clearing | ((32'(q_count) + 32'(stage_valid)) >= 32'(QUEUE_DEPTH));
  assign accept = start & ~busy;

  // range check against both the live sizes and the store geometry
  always_comb begin
    in_range = (32'(request.cluster_index) < 32'(num_clusters)) &&
               (32'(request.cluster_index) < MAX_CL_U) &&
               (32'(request.channel_index) < 32'(num_channels)) &&
               (32'(request.channel_index) < MAX_CH_U) &&
               (32'(request.time_offset) < 32'(clip_length)) &&
               (32'(request.time_offset) < MAX_T_U);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels <= pcca_pkg::NCH_W'(1);
      clip_length  <= pcca_pkg::CLIP_W'(1);
      num_clusters <= pcca_pkg::NCL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcca_pkg::REG_NUM_CHANNELS: num_channels <= cfg_data[pcca_pkg::NCH_W-1:0];
        pcca_pkg::REG_CLIP_LENGTH:  clip_length  <= cfg_data[pcca_pkg::CLIP_W-1:0];
        pcca_pkg::REG_NUM_CLUSTERS: num_clusters <= cfg_data[pcca_pkg::NCL_W-1:0];
        default: ;
      endcase
    end
  end

  // one-item stage in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept;
    end
    if (accept) begin
      stage_item.req      <= request;
      stage_item.in_range <= in_range;
    end
  end

  assign push      = stage_valid;
  assign push_item = stage_item;

  // the staged item always finds a free slot
  a_stage_room: assert property (@(posedge clk) disable iff (rst)
    stage_valid |-> (32'(q_count) < 32'(QUEUE_DEPTH)))
    else $error("staged item with a full queue");

endmodule

// ----- rtl/pcca_back.sv -----
// ----------------------------------------------------------------------------
// pcca_back
// Store clearing, sum read-modify-write, count update and template reads.
// ----------------------------------------------------------------------------
module pcca_back #(
  parameter int MAX_CLUSTERS = pcca_pkg::DEF_MAX_CLUSTERS,
  parameter int MAX_CHANNELS = pcca_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_CLIP     = pcca_pkg::DEF_MAX_CLIP
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  pcca_pkg::pcca_item_t q_head,
  output logic                 pop,
  output logic                 clearing,
  output logic                 result_valid,
  output pcca_pkg::pcca_out_t  result
);

  localparam int SUM_DEPTH = MAX_CLUSTERS * MAX_CHANNELS * MAX_CLIP;
  localparam int SUM_AW    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
  localparam int CNT_AW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int SW        = pcca_pkg::SUM_W;
  localparam int NW        = pcca_pkg::COUNT_W;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_DIV} state_t;

  state_t                state;
  logic [SUM_AW-1:0]     sweep;
  pcca_pkg::pcca_item_t  cur;
  logic [NW-1:0]         cnt_hold;
  logic                  neg_hold;

  logic                  sum_we;
  logic [SUM_AW-1:0]     sum_waddr;
  logic [SW-1:0]         sum_wdata;
  logic [SUM_AW-1:0]     sum_raddr;
  logic [SW-1:0]         sum_rd;
  logic                  cnt_we;
  logic [CNT_AW-1:0]     cnt_waddr;
  logic [NW-1:0]         cnt_wdata;
  logic [CNT_AW-1:0]     cnt_raddr;
  logic [NW-1:0]         cnt_rd;

  logic [SW:0]           sum_wide;
  logic [SW-1:0]         sum_sat;
  logic [NW-1:0]         cnt_inc;
  logic                  div_start;
  logic                  div_done;
  logic [SW-1:0]         div_mag;
  logic [SW-1:0]         div_quo;
  logic [SW-1:0]         quo_neg;
  logic [pcca_pkg::MEAN_W-1:0] mean_sat;

  // flat sum address of (cluster, channel, time)
  function automatic logic [SUM_AW-1:0] sum_addr(input pcca_pkg::pcca_in_t r);
    logic [31:0] a;
    a = (32'(r.cluster_index) * 32'(MAX_CHANNELS) + 32'(r.channel_index)) * 32'(MAX_CLIP)
        + 32'(r.time_offset);
    return a[SUM_AW-1:0];
  endfunction

  function automatic logic [CNT_AW-1:0] cnt_addr(input pcca_pkg::pcca_in_t r);
    logic [31:0] a;
    a = 32'(r.cluster_index);
    return a[CNT_AW-1:0];
  endfunction

  assign clearing  = (state == S_CLEAR);
  assign pop       = (state == S_IDLE) && !q_empty;
  assign sum_raddr = sum_addr(q_head.req);
  assign cnt_raddr = cnt_addr(q_head.req);

  // saturating sum and count update
  always_comb begin
    sum_wide = {sum_rd[SW-1], sum_rd}
             + {{(SW + 1 - pcca_pkg::SAMPLE_W){cur.req.sample_value[pcca_pkg::SAMPLE_W-1]}},
                cur.req.sample_value};
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_sat = sum_wide[SW] ? pcca_pkg::SUM_NEG_MIN : pcca_pkg::SUM_POS_MAX;
    end else begin
      sum_sat = sum_wide[SW-1:0];
    end
    cnt_inc = (cnt_rd != pcca_pkg::COUNT_MAX) ? cnt_rd + 1'b1 : cnt_rd;
  end

  // store write ports: clearing sweep or accumulate write-back
  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = sweep;
    sum_wdata = '0;
    cnt_we    = 1'b0;
    cnt_waddr = sweep[CNT_AW-1:0];
    cnt_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        sum_we = 1'b1;
        cnt_we = (32'(sweep) < 32'(MAX_CLUSTERS));
      end
      S_EXEC: begin
        if (cur.req.opcode == pcca_pkg::OP_ACCUMULATE && cur.in_range) begin
          sum_we    = 1'b1;
          sum_waddr = sum_addr(cur.req);
          sum_wdata = sum_sat;
          cnt_we    = cur.req.end_of_event;
          cnt_waddr = cnt_addr(cur.req);
          cnt_wdata = cnt_inc;
        end
      end
      default: ;
    endcase
  end

  // divide setup and quotient saturation
  always_comb begin
    div_start = (state == S_EXEC) && (cur.req.opcode == pcca_pkg::OP_READ) &&
                cur.in_range && (cnt_rd != '0);
    div_mag   = sum_rd[SW-1] ? (~sum_rd + 1'b1) : sum_rd;
    quo_neg   = ~div_quo + 1'b1;
    if (neg_hold) begin
      mean_sat = (div_quo > SW'(32768)) ? pcca_pkg::MEAN_NEG_MIN
                                        : quo_neg[pcca_pkg::MEAN_W-1:0];
    end else begin
      mean_sat = (div_quo > SW'(32767)) ? pcca_pkg::MEAN_POS_MAX
                                        : div_quo[pcca_pkg::MEAN_W-1:0];
    end
  end

  pcca_ram #(.WIDTH(SW), .DEPTH(SUM_DEPTH)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rd)
  );

  pcca_ram #(.WIDTH(NW), .DEPTH(MAX_CLUSTERS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  pcca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (cnt_rd),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      sweep        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == SUM_AW'(SUM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_head;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cur.req.opcode == pcca_pkg::OP_ACCUMULATE) begin
            state <= S_IDLE;
          end else if (!cur.in_range) begin
            result_valid       <= 1'b1;
            result.mean_value  <= '0;
            result.event_count <= '0;
            result.index_error <= 1'b1;
            state              <= S_IDLE;
          end else if (cnt_rd == '0) begin
            result_valid       <= 1'b1;
            result.mean_value  <= '0;
            result.event_count <= '0;
            result.index_error <= 1'b0;
            state              <= S_IDLE;
          end else begin
            cnt_hold <= cnt_rd;
            neg_hold <= sum_rd[SW-1];
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            result_valid       <= 1'b1;
            result.mean_value  <= mean_sat;
            result.event_count <= cnt_hold;
            result.index_error <= 1'b0;
            state              <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !pop)
    else $error("item taken during clearing pass");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide wait");

  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("results on consecutive cycles");

endmodule

// ----- rtl/per_cluster_clip_averager_unit.sv -----
// ----------------------------------------------------------------------------
// per_cluster_clip_averager_unit
// Builds one averaged waveform per cluster from accumulated samples and
// returns sum / event count on read.
// ----------------------------------------------------------------------------
// Each accumulate item takes an idle and an execute state of the back sequencer,
// set by the sum RAM read-modify-write. A read with nonzero count then waits in
// the divide state for the one-bit-per-cycle divider; other reads answer from S_EXEC.
// After rst the stores are swept to zero, one entry per cycle, over all
// MAX_CLUSTERS*MAX_CHANNELS*MAX_CLIP sum entries (65536 by default), busy held high;
// configuration writes are taken at any time. Results cannot be held off.
module per_cluster_clip_averager_unit #(
  parameter int MAX_CLUSTERS = pcca_pkg::DEF_MAX_CLUSTERS,
  parameter int MAX_CHANNELS = pcca_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_CLIP     = pcca_pkg::DEF_MAX_CLIP,
  parameter int QUEUE_DEPTH  = pcca_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  pcca_pkg::pcca_in_t              request,
  output logic                            result_valid,
  output pcca_pkg::pcca_out_t             result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcca_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic                 clearing;
  logic                 push;
  pcca_pkg::pcca_item_t push_item;
  logic                 pop;
  pcca_pkg::pcca_item_t q_head;
  logic                 q_empty;
  logic [CW-1:0]        q_count;

  pcca_front #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_CLIP     (MAX_CLIP),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  pcca_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  pcca_back #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_CLIP     (MAX_CLIP)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .pop          (pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ----- sim/per_cluster_clip_averager_unit_test.sv -----
// ----------------------------------------------------------------------------
// per_cluster_clip_averager_unit_test
// Self-checking bench for the per-cluster clip averager. A directed table hits
// the reset sizes, index extremes, out-of-range drops and errors, zero-count
// reads, mean clipping and truncation toward zero, then random phases under
// several register settings. Every read result is checked field by field against
// the row's fields where given, else a bench copy of the sum and count stores.
// ----------------------------------------------------------------------------
module per_cluster_clip_averager_unit_test;

  localparam int SETTLE_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT  = 300000;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES      = 6;
  localparam longint SUM_HI = 64'sd549755813887;
  localparam longint SUM_LO = -SUM_HI - 64'sd1;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                            kind;
    pcca_pkg::pcca_in_t                   req;
    bit                                   typed;
    pcca_pkg::pcca_out_t                  want;
    logic [pcca_pkg::CFG_IDX_W-1:0]       reg_idx;
    logic [pcca_pkg::CFG_DATA_W-1:0]      reg_val;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic                            busy;
  pcca_pkg::pcca_in_t              request = '0;
  logic                            result_valid;
  pcca_pkg::pcca_out_t             result;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pcca_pkg::CFG_IDX_W-1:0]  cfg_index = pcca_pkg::REG_NUM_CHANNELS;
  logic [pcca_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // bench copy of the block state
  logic [pcca_pkg::NCH_W-1:0]  nch_reg = pcca_pkg::NCH_W'(1);
  logic [pcca_pkg::CLIP_W-1:0] clip_reg = pcca_pkg::CLIP_W'(1);
  logic [pcca_pkg::NCL_W-1:0]  ncl_reg = pcca_pkg::NCL_W'(1);
  longint                      sum_tab [0:65535];
  bit [pcca_pkg::COUNT_W-1:0]  count_tab [0:63];

  pcca_pkg::pcca_out_t  awaited_results [$];
  stim_row_t            directed_rows [$];
  int         phase_plan [NUM_PHASES][3] = '{'{2, 4, 3}, '{1, 1, 1}, '{16, 64, 64},
                                             '{1, 1, 1}, '{127, 127, 127}, '{3, 2, 5}};
  bit         steady = 1'b0;
  int         mismatches = 0;
  int         idle_cycles = 0;

  per_cluster_clip_averager_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // index check against the current sizes
  function automatic bit in_range(input pcca_pkg::pcca_in_t req);
    return ({1'b0, req.cluster_index} < ncl_reg) &&
           ({1'b0, req.channel_index} < nch_reg) &&
           ({1'b0, req.time_offset} < clip_reg);
  endfunction

  // applies one item to the store copy, returns 1 when it yields a result
  function automatic bit average_item(input pcca_pkg::pcca_in_t req,
                                      output pcca_pkg::pcca_out_t res);
    logic [15:0]                slot;
    longint                     acc;
    longint                     q;
    bit [pcca_pkg::COUNT_W-1:0] n;
    slot = {req.cluster_index, req.channel_index, req.time_offset};
    res = '0;
    if (req.opcode == pcca_pkg::OP_ACCUMULATE) begin
      if (in_range(req)) begin
        acc = sum_tab[slot] + longint'($signed(req.sample_value));
        if (acc > SUM_HI) acc = SUM_HI;
        if (acc < SUM_LO) acc = SUM_LO;
        sum_tab[slot] = acc;
        if (req.end_of_event && count_tab[req.cluster_index] != pcca_pkg::COUNT_MAX)
          count_tab[req.cluster_index] = count_tab[req.cluster_index] + 1'b1;
      end
      return 1'b0;
    end
    if (!in_range(req)) begin
      res.index_error = 1'b1;
      return 1'b1;
    end
    n = count_tab[req.cluster_index];
    q = 0;
    if (n != 0) begin
      q = sum_tab[slot] / longint'({40'b0, n});
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
    end
    res.mean_value  = q[pcca_pkg::MEAN_W-1:0];
    res.event_count = n;
    return 1'b1;
  endfunction

  // table row builders
  function automatic stim_row_t item_row(input logic op, input int cl, input int ch,
                                         input int t, input int smp, input logic eoe);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.req.opcode        = op;
    row.req.cluster_index = pcca_pkg::CLUSTER_W'(cl);
    row.req.channel_index = pcca_pkg::CHANNEL_W'(ch);
    row.req.time_offset   = pcca_pkg::TIME_W'(t);
    row.req.sample_value  = pcca_pkg::SAMPLE_W'(smp);
    row.req.end_of_event  = eoe;
    row.typed   = 1'b0;
    row.want    = '0;
    row.reg_idx = pcca_pkg::REG_NUM_CHANNELS;
    row.reg_val = '0;
    return row;
  endfunction

  function automatic stim_row_t checked_row(input logic op, input int cl, input int ch,
                                            input int t, input logic eoe, input int mean,
                                            input int cnt, input logic err);
    stim_row_t row;
    row = item_row(op, cl, ch, t, 0, eoe);
    row.typed = 1'b1;
    row.want.mean_value  = pcca_pkg::MEAN_W'(mean);
    row.want.event_count = pcca_pkg::COUNT_W'(cnt);
    row.want.index_error = err;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [pcca_pkg::CFG_IDX_W-1:0] idx,
                                        input int val);
    stim_row_t row;
    row = item_row(pcca_pkg::OP_ACCUMULATE, 0, 0, 0, 0, 1'b0);
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = pcca_pkg::CFG_DATA_W'(val);
    return row;
  endfunction

  // mostly in-range accumulates and reads, the rest raw noise
  function automatic pcca_pkg::pcca_in_t random_item();
    pcca_pkg::pcca_in_t req;
    int                 pick;
    int                 lim_cl;
    int                 lim_ch;
    int                 lim_t;
    lim_cl = (ncl_reg > 64) ? 64 : ncl_reg;
    lim_ch = (nch_reg > 16) ? 16 : nch_reg;
    lim_t  = (clip_reg > 64) ? 64 : clip_reg;
    pick = $urandom_range(99);
    req.opcode        = 1'($urandom_range(1));
    req.cluster_index = pcca_pkg::CLUSTER_W'($urandom_range(63));
    req.channel_index = pcca_pkg::CHANNEL_W'($urandom_range(15));
    req.time_offset   = pcca_pkg::TIME_W'($urandom_range(63));
    req.sample_value  = pcca_pkg::SAMPLE_W'($urandom_range(16'hFFFF));
    req.end_of_event  = 1'($urandom_range(1));
    if (pick < 85 && lim_cl != 0 && lim_ch != 0 && lim_t != 0) begin
      req.opcode        = (pick < 55) ? pcca_pkg::OP_ACCUMULATE : pcca_pkg::OP_READ;
      req.cluster_index = pcca_pkg::CLUSTER_W'($urandom_range(lim_cl - 1));
      req.channel_index = pcca_pkg::CHANNEL_W'($urandom_range(lim_ch - 1));
      req.time_offset   = pcca_pkg::TIME_W'($urandom_range(lim_t - 1));
      req.end_of_event  = ($urandom_range(4) == 0);
      case ($urandom_range(9))
        0: req.sample_value = 16'sh7FFF;
        1: req.sample_value = 16'sh8000;
        default: ;
      endcase
    end
    return req;
  endfunction

  // drive one item, record its expected result once accepted
  task automatic send_item(input pcca_pkg::pcca_in_t req, input bit typed,
                           input pcca_pkg::pcca_out_t want);
    pcca_pkg::pcca_out_t res;
    int                  gap;
    gap = (!steady && $urandom_range(99) < 22) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    if (average_item(req, res))
      awaited_results.push_back(typed ? want : res);
  endtask

  // stop sending and wait until every read has answered
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // register write with the block idle
  task automatic write_reg(input logic [pcca_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pcca_pkg::CFG_DATA_W-1:0] val);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pcca_pkg::REG_NUM_CHANNELS: nch_reg  = val[pcca_pkg::NCH_W-1:0];
      pcca_pkg::REG_CLIP_LENGTH:  clip_reg = val[pcca_pkg::CLIP_W-1:0];
      pcca_pkg::REG_NUM_CLUSTERS: ncl_reg  = val[pcca_pkg::NCL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    pcca_pkg::pcca_out_t want;
    if (!rst && result_valid) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, mean %0d count %0d error %0b", $time,
                 $signed(result.mean_value), result.event_count, result.index_error);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (result.mean_value !== want.mean_value) begin
          $display("%0t: mean_value expected %0d got %0d", $time,
                   $signed(want.mean_value), $signed(result.mean_value));
          mismatches++;
        end
        if (result.event_count !== want.event_count) begin
          $display("%0t: event_count expected %0d got %0d", $time,
                   want.event_count, result.event_count);
          mismatches++;
        end
        if (result.index_error !== want.index_error) begin
          $display("%0t: index_error expected %0b got %0b", $time,
                   want.index_error, result.index_error);
          mismatches++;
        end
      end
    end
  end

  // watchdog on stretches with no handshake at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("per_cluster_clip_averager_unit: mismatch");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    // reset sizes: one cluster, one channel, one slot
    directed_rows.push_back(checked_row(pcca_pkg::OP_READ, 0, 0, 0, 1'b1, 0, 0, 1'b0));
    directed_rows.push_back(checked_row(pcca_pkg::OP_READ, 63, 15, 63, 1'b0, 0, 0, 1'b1));
    directed_rows.push_back(item_row(pcca_pkg::OP_ACCUMULATE, 1, 0, 0, 100, 1'b1));
    directed_rows.push_back(checked_row(pcca_pkg::OP_READ, 1, 0, 0, 1'b0, 0, 0, 1'b1));
    directed_rows.push_back(checked_row(pcca_pkg::OP_READ, 0, 0, 0, 1'b0, 0, 0, 1'b0));
    // full sizes
    directed_rows.push_back(reg_row(pcca_pkg::REG_NUM_CHANNELS, 16));
    directed_rows.push_back(reg_row(pcca_pkg::REG_CLIP_LENGTH, 64));
    directed_rows.push_back(reg_row(pcca_pkg::REG_NUM_CLUSTERS, 64));
    // mean clips at both ends
    directed_rows.push_back(item_row(pcca_pkg::OP_ACCUMULATE, 63, 15, 63, 32767, 1'b0));
    directed_rows.push_back(item_row(pcca_pkg::OP_ACCUMULATE, 63, 15, 63, 32767, 1'b1));
    directed_rows.push_back(checked_row(pcca_pkg::OP_READ, 63, 15, 63, 1'b0, 32767, 1,
                                        1'b0));
    directed_rows.push_back(item_row(pcca_pkg::OP_ACCUMULATE, 0, 0, 0, -32768, 1'b0));
    directed_rows.push_back(item_row(pcca_pkg::OP_ACCUMULATE, 0, 0, 0, -32768, 1'b1));
    directed_rows.push_back(checked_row(pcca_pkg::OP_READ, 0, 0, 0, 1'b0, -32768, 1,
                                        1'b0));
    // negative quotient truncates toward zero
    directed_rows.push_back(item_row(pcca_pkg::OP_ACCUMULATE, 5, 3, 7, -7, 1'b1));
    directed_rows.push_back(item_row(pcca_pkg::OP_ACCUMULATE, 5, 3, 8, 0, 1'b1));
    directed_rows.push_back(checked_row(pcca_pkg::OP_READ, 5, 3, 7, 1'b0, -3, 2, 1'b0));
    directed_rows.push_back(checked_row(pcca_pkg::OP_READ, 6, 0, 0, 1'b0, 0, 0, 1'b0));
    directed_rows.push_back(item_row(pcca_pkg::OP_ACCUMULATE, 5, 3, 7, -1, 1'b0));
    // zero cluster count puts everything out of range
    directed_rows.push_back(reg_row(pcca_pkg::REG_NUM_CLUSTERS, 0));
    directed_rows.push_back(checked_row(pcca_pkg::OP_READ, 0, 0, 0, 1'b0, 0, 0, 1'b1));
    directed_rows.push_back(item_row(pcca_pkg::OP_ACCUMULATE, 0, 0, 0, 5, 1'b1));
    // oversized values, stores kept across writes
    directed_rows.push_back(reg_row(pcca_pkg::REG_NUM_CHANNELS, 127));
    directed_rows.push_back(reg_row(pcca_pkg::REG_CLIP_LENGTH, 127));
    directed_rows.push_back(reg_row(pcca_pkg::REG_NUM_CLUSTERS, 127));
    directed_rows.push_back(checked_row(pcca_pkg::OP_READ, 0, 0, 0, 1'b0, -32768, 1,
                                        1'b0));
    directed_rows.push_back(item_row(pcca_pkg::OP_READ, 5, 3, 7, 0, 1'b0));
    // channel and time limits
    directed_rows.push_back(reg_row(pcca_pkg::REG_NUM_CHANNELS, 4));
    directed_rows.push_back(reg_row(pcca_pkg::REG_CLIP_LENGTH, 2));
    directed_rows.push_back(checked_row(pcca_pkg::OP_READ, 63, 4, 0, 1'b0, 0, 0, 1'b1));
    directed_rows.push_back(checked_row(pcca_pkg::OP_READ, 63, 3, 2, 1'b0, 0, 0, 1'b1));
    directed_rows.push_back(checked_row(pcca_pkg::OP_READ, 63, 3, 1, 1'b0, 0, 1, 1'b0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG)
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      else
        send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases, one size setting each; phase two runs without gaps
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 3) begin
        phase_plan[p][0] = $urandom_range(1, 16);
        phase_plan[p][1] = $urandom_range(1, 64);
        phase_plan[p][2] = $urandom_range(1, 64);
      end
      write_reg(pcca_pkg::REG_NUM_CHANNELS, pcca_pkg::CFG_DATA_W'(phase_plan[p][0]));
      write_reg(pcca_pkg::REG_CLIP_LENGTH, pcca_pkg::CFG_DATA_W'(phase_plan[p][1]));
      write_reg(pcca_pkg::REG_NUM_CLUSTERS, pcca_pkg::CFG_DATA_W'(phase_plan[p][2]));
      steady = (p == 2);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (!steady && $urandom_range(39) == 0) drain_results();
        send_item(random_item(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("per_cluster_clip_averager_unit: match");
    else
      $display("per_cluster_clip_averager_unit: mismatch");
    $finish;
  end

endmodule
